// ----- design/lpca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpca_pkg
// Types, widths and arithmetic helpers for the line pair closest approach
// pipeline.
// ----------------------------------------------------------------------------
package lpca_pkg;

	localparam int CW  = 16;          // coordinate width
	localparam int XW  = CW + 1;      // point difference / sum width
	localparam int DW  = 36;          // dot product width
	localparam int PW  = 72;          // den, sn, tn width
	localparam int NW  = 92;          // numerator width
	localparam int CH  = 18;          // multiplier chunk width
	localparam int QW  = CW + 1;      // quotient bits before rounding
	localparam int LN  = 6;           // divider lanes: vertex x/y/z, gap x/y/z

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t first_point_x;
		coord_t first_point_y;
		coord_t first_point_z;
		coord_t first_dir_x;
		coord_t first_dir_y;
		coord_t first_dir_z;
		coord_t second_point_x;
		coord_t second_point_y;
		coord_t second_point_z;
		coord_t second_dir_x;
		coord_t second_dir_y;
		coord_t second_dir_z;
	} req_t;

	typedef struct packed {
		coord_t vertex_x;
		coord_t vertex_y;
		coord_t vertex_z;
		coord_t gap_x;
		coord_t gap_y;
		coord_t gap_z;
		logic   parallel_flag;
		logic   overflow_flag;
	} res_t;

	function automatic logic signed [DW-1:0] dot3(
		input logic signed [XW-1:0] x0, input logic signed [XW-1:0] x1,
		input logic signed [XW-1:0] x2, input logic signed [XW-1:0] y0,
		input logic signed [XW-1:0] y1, input logic signed [XW-1:0] y2);
		logic signed [2*XW-1:0] m0;
		logic signed [2*XW-1:0] m1;
		logic signed [2*XW-1:0] m2;
		m0 = x0 * y0;
		m1 = x1 * y1;
		m2 = x2 * y2;
		return DW'(m0) + DW'(m1) + DW'(m2);
	endfunction

	// chunk of a 36-bit operand: low part unsigned, high part signed
	function automatic logic signed [CH:0] chk36(input logic signed [DW-1:0] x,
		input logic hi);
		return hi ? {x[DW-1], x[DW-1:CH]} : {1'b0, x[CH-1:0]};
	endfunction

	function automatic logic signed [CH:0] chk72(input logic signed [PW-1:0] x,
		input logic [1:0] k);
		if (k == 2'd3) begin
			return {x[PW-1], x[PW-1 -: CH]};
		end
		return {1'b0, x[k*CH +: CH]};
	endfunction

	function automatic logic signed [2*CH+1:0] smul(input logic signed [CH:0] x,
		input logic signed [CH:0] y);
		return x * y;
	endfunction

	function automatic logic signed [PW-1:0] sum36(
		input logic signed [2*CH+1:0] p0, input logic signed [2*CH+1:0] p1,
		input logic signed [2*CH+1:0] p2, input logic signed [2*CH+1:0] p3);
		return PW'(p0) + (PW'(p1) <<< CH) + (PW'(p2) <<< CH) + (PW'(p3) <<< (2*CH));
	endfunction

	function automatic logic signed [NW-1:0] sum72(
		input logic signed [2*CH+1:0] p0, input logic signed [2*CH+1:0] p1,
		input logic signed [2*CH+1:0] p2, input logic signed [2*CH+1:0] p3);
		return NW'(p0) + (NW'(p1) <<< CH) + (NW'(p2) <<< (2*CH)) + (NW'(p3) <<< (3*CH));
	endfunction

	function automatic logic [NW-1:0] absn(input logic signed [NW-1:0] x);
		return x[NW-1] ? NW'(-x) : NW'(x);
	endfunction

	function automatic logic [PW-1:0] absp(input logic signed [PW-1:0] x);
		return x[PW-1] ? PW'(-x) : PW'(x);
	endfunction

	// vertex lanes divide by 2*den, gap lanes by den
	function automatic logic [NW-1:0] lane_div(input int lane, input logic [PW-1:0] dm);
		return (lane < 3) ? NW'({dm, 1'b0}) : NW'(dm);
	endfunction

endpackage

// ----- design/line_pair_closest_approach.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pair_closest_approach
// Closest points of two 3D lines: midpoint vertex and gap vector, rounded to
// nearest and saturated, with parallel and overflow flags.
//
//   channel | handshake             | payload
//   request | req_valid / req_ready | req_data (lpca_pkg::req_t)
//   result  | res_valid / res_ready | res_data (lpca_pkg::res_t)
//
// One request per cycle unless a stalled result holds the pipeline.
// The 17-step restoring divider computes one quotient bit a stage.
// arst_n clears all valid bits; data registers are not reset.
// A stalled result holds the whole pipeline; req_ready = !res_valid | res_ready.
// ----------------------------------------------------------------------------
module line_pair_closest_approach (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  lpca_pkg::req_t   req_data,
	output logic             res_valid,
	input  logic             res_ready,
	output lpca_pkg::res_t   res_data
);

	localparam int NST = 8 + (lpca_pkg::QW + 1) + 2;
	localparam int DV0 = 8;
	localparam int RND = DV0 + lpca_pkg::QW + 1;

	logic           en;
	logic [NST-1:0] vld_s;

	lpca_pkg::coord_t p1_c [3];
	lpca_pkg::coord_t p2_c [3];
	lpca_pkg::coord_t da_c [3];
	lpca_pkg::coord_t db_c [3];

	assign en        = !vld_s[NST-1] || res_ready;
	assign req_ready = en;
	assign res_valid = vld_s[NST-1];

	assign p1_c[0] = req_data.first_point_x;
	assign p1_c[1] = req_data.first_point_y;
	assign p1_c[2] = req_data.first_point_z;
	assign da_c[0] = req_data.first_dir_x;
	assign da_c[1] = req_data.first_dir_y;
	assign da_c[2] = req_data.first_dir_z;
	assign p2_c[0] = req_data.second_point_x;
	assign p2_c[1] = req_data.second_point_y;
	assign p2_c[2] = req_data.second_point_z;
	assign db_c[0] = req_data.second_dir_x;
	assign db_c[1] = req_data.second_dir_y;
	assign db_c[2] = req_data.second_dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], req_valid};
		end
	end

	// s1: point difference and sum
	lpca_pkg::coord_t                 da_s1 [3], db_s1 [3];
	logic signed [lpca_pkg::XW-1:0]   d0_s1 [3], ps_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				da_s1[i] <= da_c[i];
				db_s1[i] <= db_c[i];
				d0_s1[i] <= lpca_pkg::XW'(p1_c[i]) - lpca_pkg::XW'(p2_c[i]);
				ps_s1[i] <= lpca_pkg::XW'(p1_c[i]) + lpca_pkg::XW'(p2_c[i]);
			end
		end
	end

	// s2: dot products
	logic signed [lpca_pkg::DW-1:0] a_s2, b_s2, c_s2, d_s2, e_s2;
	lpca_pkg::coord_t               da_s2 [3], db_s2 [3];
	logic signed [lpca_pkg::XW-1:0] d0_s2 [3], ps_s2 [3];
	logic signed [lpca_pkg::XW-1:0] dax [3], dbx [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dax[i] = lpca_pkg::XW'(da_s1[i]);
			dbx[i] = lpca_pkg::XW'(db_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2  <= lpca_pkg::dot3(dax[0], dax[1], dax[2], dax[0], dax[1], dax[2]);
			b_s2  <= lpca_pkg::dot3(dax[0], dax[1], dax[2], dbx[0], dbx[1], dbx[2]);
			c_s2  <= lpca_pkg::dot3(dbx[0], dbx[1], dbx[2], dbx[0], dbx[1], dbx[2]);
			d_s2  <= lpca_pkg::dot3(dax[0], dax[1], dax[2],
				d0_s1[0], d0_s1[1], d0_s1[2]);
			e_s2  <= lpca_pkg::dot3(dbx[0], dbx[1], dbx[2],
				d0_s1[0], d0_s1[1], d0_s1[2]);
			da_s2 <= da_s1;
			db_s2 <= db_s1;
			d0_s2 <= d0_s1;
			ps_s2 <= ps_s1;
		end
	end

	// s3: partial products of a*c, b*b, b*e, c*d, a*e, b*d
	logic signed [2*lpca_pkg::CH+1:0] pp_s3 [6][4];
	lpca_pkg::coord_t                 da_s3 [3], db_s3 [3];
	logic signed [lpca_pkg::XW-1:0]   d0_s3 [3], ps_s3 [3];
	logic signed [lpca_pkg::DW-1:0]   opx [6], opy [6];

	always_comb begin
		opx[0] = a_s2; opy[0] = c_s2;
		opx[1] = b_s2; opy[1] = b_s2;
		opx[2] = b_s2; opy[2] = e_s2;
		opx[3] = c_s2; opy[3] = d_s2;
		opx[4] = a_s2; opy[4] = e_s2;
		opx[5] = b_s2; opy[5] = d_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				pp_s3[j][0] <= lpca_pkg::smul(lpca_pkg::chk36(opx[j], 1'b0),
					lpca_pkg::chk36(opy[j], 1'b0));
				pp_s3[j][1] <= lpca_pkg::smul(lpca_pkg::chk36(opx[j], 1'b0),
					lpca_pkg::chk36(opy[j], 1'b1));
				pp_s3[j][2] <= lpca_pkg::smul(lpca_pkg::chk36(opx[j], 1'b1),
					lpca_pkg::chk36(opy[j], 1'b0));
				pp_s3[j][3] <= lpca_pkg::smul(lpca_pkg::chk36(opx[j], 1'b1),
					lpca_pkg::chk36(opy[j], 1'b1));
			end
			da_s3 <= da_s2;
			db_s3 <= db_s2;
			d0_s3 <= d0_s2;
			ps_s3 <= ps_s2;
		end
	end

	// s4: den, sn, tn
	logic signed [lpca_pkg::PW-1:0] den_s4, sn_s4, tn_s4;
	lpca_pkg::coord_t               da_s4 [3], db_s4 [3];
	logic signed [lpca_pkg::XW-1:0] d0_s4 [3], ps_s4 [3];
	logic signed [lpca_pkg::PW-1:0] prd [6];

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			prd[j] = lpca_pkg::sum36(pp_s3[j][0], pp_s3[j][1], pp_s3[j][2], pp_s3[j][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s4 <= prd[0] - prd[1];
			sn_s4  <= prd[2] - prd[3];
			tn_s4  <= prd[4] - prd[5];
			da_s4  <= da_s3;
			db_s4  <= db_s3;
			d0_s4  <= d0_s3;
			ps_s4  <= ps_s3;
		end
	end

	// s5: partials of sn*da, tn*db, den*d0, den*ps
	logic signed [2*lpca_pkg::CH+1:0] mp_s5 [12][4];
	logic signed [lpca_pkg::PW-1:0]   den_s5;
	logic                             par_s5;
	logic signed [lpca_pkg::PW-1:0]   mx [12];
	logic signed [lpca_pkg::CH:0]     my [12];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mx[i]     = sn_s4;  my[i]     = (lpca_pkg::CH+1)'(da_s4[i]);
			mx[3+i]   = tn_s4;  my[3+i]   = (lpca_pkg::CH+1)'(db_s4[i]);
			mx[6+i]   = den_s4; my[6+i]   = (lpca_pkg::CH+1)'(d0_s4[i]);
			mx[9+i]   = den_s4; my[9+i]   = (lpca_pkg::CH+1)'(ps_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 12; j++) begin
				for (int k = 0; k < 4; k++) begin
					mp_s5[j][k] <= lpca_pkg::smul(lpca_pkg::chk72(mx[j], 2'(k)), my[j]);
				end
			end
			den_s5 <= den_s4;
			par_s5 <= (den_s4 == '0);
		end
	end

	// s6: product sums
	logic signed [lpca_pkg::NW-1:0] pr_s6 [12];
	logic signed [lpca_pkg::PW-1:0] den_s6;
	logic                           par_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 12; j++) begin
				pr_s6[j] <= lpca_pkg::sum72(mp_s5[j][0], mp_s5[j][1], mp_s5[j][2],
					mp_s5[j][3]);
			end
			den_s6 <= den_s5;
			par_s6 <= par_s5;
		end
	end

	// s7: numerators, lanes 0..2 vertex, 3..5 gap
	logic signed [lpca_pkg::NW-1:0] num_s7 [lpca_pkg::LN];
	logic signed [lpca_pkg::PW-1:0] den_s7;
	logic                           par_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s7[i]   <= pr_s6[9+i] + pr_s6[i] + pr_s6[3+i];
				num_s7[3+i] <= pr_s6[6+i] + pr_s6[i] - pr_s6[3+i];
			end
			den_s7 <= den_s6;
			par_s7 <= par_s6;
		end
	end

	// s8: sign and magnitude
	logic [lpca_pkg::NW-1:0] mag_s8 [lpca_pkg::LN];
	logic                    neg_s8 [lpca_pkg::LN];
	logic [lpca_pkg::PW-1:0] dm_s8;
	logic                    par_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < lpca_pkg::LN; i++) begin
				mag_s8[i] <= lpca_pkg::absn(num_s7[i]);
				neg_s8[i] <= num_s7[i][lpca_pkg::NW-1] ^ den_s7[lpca_pkg::PW-1];
			end
			dm_s8  <= lpca_pkg::absp(den_s7);
			par_s8 <= par_s7;
		end
	end

	// divider: stage 0 checks range, stages 1..QW one quotient bit each
	logic [lpca_pkg::NW-1:0] dv_rem_s [lpca_pkg::QW+1][lpca_pkg::LN];
	logic [lpca_pkg::QW-1:0] dv_q_s   [lpca_pkg::QW+1][lpca_pkg::LN];
	logic                    dv_big_s [lpca_pkg::QW+1][lpca_pkg::LN];
	logic                    dv_neg_s [lpca_pkg::QW+1][lpca_pkg::LN];
	logic [lpca_pkg::PW-1:0] dv_dm_s  [lpca_pkg::QW+1];
	logic                    dv_par_s [lpca_pkg::QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < lpca_pkg::LN; i++) begin
				dv_rem_s[0][i] <= mag_s8[i];
				dv_q_s[0][i]   <= '0;
				dv_big_s[0][i] <= mag_s8[i] >=
					(lpca_pkg::lane_div(i, dm_s8) << lpca_pkg::QW);
				dv_neg_s[0][i] <= neg_s8[i];
			end
			dv_dm_s[0]  <= dm_s8;
			dv_par_s[0] <= par_s8;
		end
	end

	for (genvar k = 1; k <= lpca_pkg::QW; k++) begin : g_div
		localparam int BIT = lpca_pkg::QW - k;
		logic [lpca_pkg::NW-1:0] sub_c [lpca_pkg::LN];
		logic                    ge_c  [lpca_pkg::LN];

		always_comb begin
			for (int i = 0; i < lpca_pkg::LN; i++) begin
				sub_c[i] = lpca_pkg::lane_div(i, dv_dm_s[k-1]) << BIT;
				ge_c[i]  = dv_rem_s[k-1][i] >= sub_c[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < lpca_pkg::LN; i++) begin
					dv_rem_s[k][i] <= ge_c[i] ? dv_rem_s[k-1][i] - sub_c[i]
						: dv_rem_s[k-1][i];
					dv_q_s[k][i]   <= dv_q_s[k-1][i] |
						(lpca_pkg::QW'(ge_c[i]) << BIT);
					dv_big_s[k][i] <= dv_big_s[k-1][i];
					dv_neg_s[k][i] <= dv_neg_s[k-1][i];
				end
				dv_dm_s[k]  <= dv_dm_s[k-1];
				dv_par_s[k] <= dv_par_s[k-1];
			end
		end
	end

	// rounding: half or more of the divisor left rounds the magnitude up
	logic [lpca_pkg::QW:0] qr_rnd [lpca_pkg::LN];
	logic                  big_rnd [lpca_pkg::LN];
	logic                  neg_rnd [lpca_pkg::LN];
	logic                  par_rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < lpca_pkg::LN; i++) begin
				qr_rnd[i]  <= (lpca_pkg::QW+1)'(dv_q_s[lpca_pkg::QW][i]) +
					(lpca_pkg::QW+1)'({dv_rem_s[lpca_pkg::QW][i][lpca_pkg::NW-2:0], 1'b0} >=
					lpca_pkg::lane_div(i, dv_dm_s[lpca_pkg::QW]));
				big_rnd[i] <= dv_big_s[lpca_pkg::QW][i];
				neg_rnd[i] <= dv_neg_s[lpca_pkg::QW][i];
			end
			par_rnd <= dv_par_s[lpca_pkg::QW];
		end
	end

	// output: saturate, apply sign, clear on parallel lines
	lpca_pkg::coord_t      crd_c [lpca_pkg::LN];
	logic                  sat_c [lpca_pkg::LN];
	logic [lpca_pkg::QW:0] lim_c [lpca_pkg::LN];
	logic [lpca_pkg::QW:0] mg_c  [lpca_pkg::LN];
	logic                  ovf_c;
	lpca_pkg::res_t        res_c;

	always_comb begin
		ovf_c = 1'b0;
		for (int i = 0; i < lpca_pkg::LN; i++) begin
			lim_c[i] = neg_rnd[i] ? (lpca_pkg::QW+1)'(1 << (lpca_pkg::CW-1))
				: (lpca_pkg::QW+1)'((1 << (lpca_pkg::CW-1)) - 1);
			sat_c[i] = big_rnd[i] || (qr_rnd[i] > lim_c[i]);
			mg_c[i]  = sat_c[i] ? lim_c[i] : qr_rnd[i];
			crd_c[i] = neg_rnd[i] ? lpca_pkg::CW'(-mg_c[i]) : lpca_pkg::CW'(mg_c[i]);
			ovf_c    = ovf_c | sat_c[i];
		end
		res_c.vertex_x      = crd_c[0];
		res_c.vertex_y      = crd_c[1];
		res_c.vertex_z      = crd_c[2];
		res_c.gap_x         = crd_c[3];
		res_c.gap_y         = crd_c[4];
		res_c.gap_z         = crd_c[5];
		res_c.parallel_flag = 1'b0;
		res_c.overflow_flag = ovf_c;
		if (par_rnd) begin
			res_c               = '0;
			res_c.parallel_flag = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_data <= res_c;
		end
	end

`ifndef NO_ASSERTIONS
	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.parallel_flag |->
			!res_data.overflow_flag && res_data.vertex_x == '0 &&
			res_data.vertex_y == '0 && res_data.vertex_z == '0 &&
			res_data.gap_x == '0 && res_data.gap_y == '0 && res_data.gap_z == '0)
		else $error("parallel result carries nonzero fields");

	a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.overflow_flag |->
			res_data.vertex_x == lpca_pkg::CMAX || res_data.vertex_x == lpca_pkg::CMIN ||
			res_data.vertex_y == lpca_pkg::CMAX || res_data.vertex_y == lpca_pkg::CMIN ||
			res_data.vertex_z == lpca_pkg::CMAX || res_data.vertex_z == lpca_pkg::CMIN ||
			res_data.gap_x == lpca_pkg::CMAX || res_data.gap_x == lpca_pkg::CMIN ||
			res_data.gap_y == lpca_pkg::CMAX || res_data.gap_y == lpca_pkg::CMIN ||
			res_data.gap_z == lpca_pkg::CMAX || res_data.gap_z == lpca_pkg::CMIN)
		else $error("overflow flagged without a saturated coordinate");

	for (genvar i = 0; i < lpca_pkg::LN; i++) begin : g_chk
		a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
			vld_s[RND-1] && !dv_par_s[lpca_pkg::QW] && !dv_big_s[lpca_pkg::QW][i] |->
				dv_rem_s[lpca_pkg::QW][i] < lpca_pkg::lane_div(i, dv_dm_s[lpca_pkg::QW]))
			else $error("divider remainder not below divisor");
	end
`endif

endmodule
